### rtl/core/b2s_pkg.sv
// ----------------------------------------------------------------------------
// b2s_pkg
// Shared types, constants and helper functions of the BLAKE2s hash engine.
// ----------------------------------------------------------------------------
package b2s_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [7:0]  chain_t;
    typedef word_t [15:0] vec_t;

    // row rotation applied to the work vector after a mix step
    localparam logic [1:0] ROT_NONE   = 2'd0;
    localparam logic [1:0] ROT_COL    = 2'd1;
    localparam logic [1:0] ROT_DIAG   = 2'd2;
    localparam logic [1:0] ROT_UNDIAG = 2'd3;

    typedef struct packed {
        logic       load;
        logic       last_blk;
        logic       step_a;
        logic       step_b;
        logic       half;
        logic [1:0] rot;
    } core_ctrl_t;

    localparam logic [5:0] DIGEST_BYTES_RST = 6'd32;
    localparam logic [5:0] DIGEST_BYTES_MAX = 6'd32;
    localparam logic [7:0] PARAM_FANOUT     = 8'd1;
    localparam logic [7:0] PARAM_DEPTH      = 8'd1;

    localparam word_t IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [3:0] SIGMA [10][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
    };

    function automatic word_t ror32(word_t w, logic [4:0] n);
        logic [63:0] dbl;
        dbl = {w, w} >> n;
        return dbl[31:0];
    endfunction

    // zero is taken as one, anything above the maximum as the maximum
    function automatic logic [5:0] eff_len(logic [5:0] d);
        logic [5:0] len;
        if (d == 6'd0) begin
            len = 6'd1;
        end else if (d > DIGEST_BYTES_MAX) begin
            len = DIGEST_BYTES_MAX;
        end else begin
            len = d;
        end
        return len;
    endfunction

    function automatic chain_t chain_init(logic [5:0] d);
        chain_t h;
        for (int i = 0; i < 8; i++) begin
            h[3'(i)] = IV[3'(i)];
        end
        h[0] = h[0] ^ {PARAM_DEPTH, PARAM_FANOUT, 8'h00, 2'b00, eff_len(d)};
        return h;
    endfunction

    function automatic logic [3:0] sigma_at(logic [3:0] rnd, logic [3:0] pos);
        return SIGMA[rnd][pos];
    endfunction

endpackage

### rtl/core/b2s_msg_buf.sv
// ----------------------------------------------------------------------------
// b2s_msg_buf
// Message block buffer: byte-wide writes, registered 32-bit word reads,
// bytes at or beyond the fill count read as zero padding.
// ----------------------------------------------------------------------------
module b2s_msg_buf (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [5:0]           wr_pos,
    input  logic [7:0]           wr_byte,
    input  logic [3:0]           rd_addr,
    input  logic [6:0]           fill,
    output b2s_pkg::word_t       rd_word
);

    logic [3:0][7:0] mem [16];
    logic [3:0][7:0] rd_q_reg;
    logic [3:0]      rd_addr_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_pos[5:2]][wr_pos[1:0]] <= wr_byte;
        end
    end

    always_ff @(posedge clk) begin
        rd_q_reg    <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    // zero padding past the buffered bytes
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if ({1'b0, rd_addr_reg, 2'(l)} < fill) begin
                rd_word[8*l +: 8] = rd_q_reg[2'(l)];
            end else begin
                rd_word[8*l +: 8] = 8'h00;
            end
        end
    end

endmodule

### rtl/core/b2s_round_core.sv
// ----------------------------------------------------------------------------
// b2s_round_core
// Work vector and shared half-mix unit. Each step updates the fixed
// column 0 of the vector; row rotations bring the next column or diagonal
// into place.
// ----------------------------------------------------------------------------
module b2s_round_core (
    input  logic                 clk,
    input  b2s_pkg::core_ctrl_t  ctrl,
    input  b2s_pkg::chain_t      chain_in,
    input  logic [63:0]          count_in,
    input  b2s_pkg::word_t       msg_word,
    output b2s_pkg::vec_t        vec_out
);

    b2s_pkg::vec_t  v_reg;
    b2s_pkg::vec_t  v_next;
    b2s_pkg::vec_t  v_init;
    b2s_pkg::vec_t  v_step;
    b2s_pkg::vec_t  v_rot;
    b2s_pkg::word_t a_sum;
    b2s_pkg::word_t d_new;
    b2s_pkg::word_t c_sum;
    b2s_pkg::word_t b_new;
    logic [1:0]     col;

    function automatic logic [1:0] rot_amt(logic [1:0] code, logic [1:0] row);
        logic [1:0] amt;
        unique case (code)
            b2s_pkg::ROT_NONE:   amt = 2'd0;
            b2s_pkg::ROT_COL:    amt = 2'd1;
            b2s_pkg::ROT_DIAG:   amt = row + 2'd1;
            b2s_pkg::ROT_UNDIAG: amt = row ^ 2'd1;
            default:             amt = 2'd0;
        endcase
        return amt;
    endfunction

    // half mix: a/d on step a, c/b on step b
    always_comb begin
        a_sum = v_reg[0] + v_reg[4] + msg_word;
        d_new = b2s_pkg::ror32(v_reg[12] ^ a_sum, ctrl.half ? 5'd8 : 5'd16);
        c_sum = v_reg[8] + v_reg[12];
        b_new = b2s_pkg::ror32(v_reg[4] ^ c_sum, ctrl.half ? 5'd7 : 5'd12);
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            v_init[{1'b0, 3'(i)}] = chain_in[3'(i)];
            v_init[{1'b1, 3'(i)}] = b2s_pkg::IV[3'(i)];
        end
        v_init[12] = v_init[12] ^ count_in[31:0];
        v_init[13] = v_init[13] ^ count_in[63:32];
        if (ctrl.last_blk) begin
            v_init[14] = ~v_init[14];
        end
    end

    always_comb begin
        v_step = v_reg;
        if (ctrl.step_a) begin
            v_step[0]  = a_sum;
            v_step[12] = d_new;
        end
        if (ctrl.step_b) begin
            v_step[8] = c_sum;
            v_step[4] = b_new;
        end
        col = 2'd0;
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
                col = 2'(j) + rot_amt(ctrl.rot, 2'(r));
                v_rot[{2'(r), 2'(j)}] = v_step[{2'(r), col}];
            end
        end
        v_next = ctrl.load ? v_init : v_rot;
    end

    always_ff @(posedge clk) begin
        v_reg <= v_next;
    end

    assign vec_out = v_reg;

endmodule

### rtl/core/blake2s_hash_engine.sv
// ----------------------------------------------------------------------------
// blake2s_hash_engine
// Unkeyed BLAKE2s over a byte stream with a configurable digest length.
// ----------------------------------------------------------------------------
// Input words (s_valid/s_ready) carry one message byte when s_has_byte is
// set, and s_end_of_message on the last word of a message; an end word
// without a byte closes the message (an empty message included).
// A byte word is written to the block buffer after it is taken. A byte
// that arrives on a full 64-byte block first compresses that block (vector
// load, 10 rounds of 32 half-mix steps on the one shared adder pair, chain
// fold). An end word, after its byte if it has one, runs the final
// compression, then the digest leaves as 1 to 8 little-endian words,
// one per cycle while m_ready is high. s_ready is low while a word is
// being worked on. If the receiver stalls, the engine waits with the
// current digest word in its output register; once the last word is
// loaded it is ready for the next message while that word still waits.
// cfg_wr_en writes the digest length (1..32, 0 read as 1, above 32 as 32)
// and restarts the chaining state; write only while the engine is idle.
// Reset (aresetn low, synchronous) sets a 32-byte digest and an empty
// message. The block buffer needs no clearing: unfilled bytes read as zero.
// ----------------------------------------------------------------------------
module blake2s_hash_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic [2:0]  m_valid_bytes,
    output logic        m_last_word,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_ROUND  = 3'd2;
    localparam logic [2:0] ST_FOLD   = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;
    localparam logic [2:0] ST_FINCNT = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    localparam logic [6:0] BLK_BYTES  = 7'd64;
    localparam logic [3:0] LAST_ROUND = 4'd9;

    logic [2:0]          state_reg, state_next;
    logic [5:0]          digest_reg, digest_next;
    b2s_pkg::chain_t     chain_reg, chain_next;
    logic [6:0]          buffered_reg, buffered_next;
    logic [63:0]         counter_reg, counter_next;
    logic                final_reg, final_next;
    logic [3:0]          rnd_reg, rnd_next;
    logic [2:0]          g_reg, g_next;
    logic [1:0]          stp_reg, stp_next;
    logic [2:0]          k_reg, k_next;
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          byte_reg;
    logic                eom_reg;
    logic [31:0]         word_reg;
    logic [2:0]          index_reg;
    logic [2:0]          vb_reg;
    logic                last_reg;

    b2s_pkg::core_ctrl_t ctrl;
    b2s_pkg::vec_t       vec;
    b2s_pkg::word_t      msg_word;
    logic                mem_wr_en;
    logic [3:0]          rd_addr;
    logic                in_take;
    logic                out_load;

    logic [5:0]          len;
    logic [6:0]          len_up;
    logic [3:0]          nwords;
    logic [5:0]          rem;
    logic [2:0]          vb;
    logic                last_k;
    logic [31:0]         out_word;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_take = s_valid && s_ready;

    // digest word shaping
    always_comb begin
        len    = b2s_pkg::eff_len(digest_reg);
        len_up = {1'b0, len} + 7'd3;
        nwords = len_up[5:2];
        rem    = len - {1'b0, k_reg, 2'b00};
        vb     = (rem > 6'd4) ? 3'd4 : rem[2:0];
        last_k = ({1'b0, k_reg} + 4'd1) == nwords;
        case (vb)
            3'd1:    out_word = {24'h0, chain_reg[k_reg][7:0]};
            3'd2:    out_word = {16'h0, chain_reg[k_reg][15:0]};
            3'd3:    out_word = {8'h0, chain_reg[k_reg][23:0]};
            default: out_word = chain_reg[k_reg];
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        digest_next   = digest_reg;
        chain_next    = chain_reg;
        buffered_next = buffered_reg;
        counter_next  = counter_reg;
        final_next    = final_reg;
        rnd_next      = rnd_reg;
        g_next        = g_reg;
        stp_next      = stp_reg;
        k_next        = k_reg;
        m_valid_next  = m_valid_reg;
        ctrl          = '0;
        mem_wr_en     = 1'b0;
        out_load      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    if (s_has_byte && buffered_reg == BLK_BYTES) begin
                        counter_next = counter_reg + 64'd64;
                        final_next   = 1'b0;
                        state_next   = ST_LOAD;
                    end else if (s_has_byte) begin
                        state_next = ST_WRITE;
                    end else if (s_end_of_message) begin
                        state_next = ST_FINCNT;
                    end
                end
            end
            ST_LOAD: begin
                ctrl.load     = 1'b1;
                ctrl.last_blk = final_reg;
                rnd_next      = 4'd0;
                g_next        = 3'd0;
                stp_next      = 2'd0;
                state_next    = ST_ROUND;
            end
            ST_ROUND: begin
                ctrl.step_a = ~stp_reg[0];
                ctrl.step_b = stp_reg[0];
                ctrl.half   = stp_reg[1];
                if (stp_reg == 2'd3) begin
                    if (g_reg == 3'd3) begin
                        ctrl.rot = b2s_pkg::ROT_DIAG;
                    end else if (g_reg == 3'd7) begin
                        ctrl.rot = b2s_pkg::ROT_UNDIAG;
                    end else begin
                        ctrl.rot = b2s_pkg::ROT_COL;
                    end
                    g_next = g_reg + 3'd1;
                    if (g_reg == 3'd7) begin
                        if (rnd_reg == LAST_ROUND) begin
                            rnd_next   = 4'd0;
                            state_next = ST_FOLD;
                        end else begin
                            rnd_next = rnd_reg + 4'd1;
                        end
                    end
                end
                stp_next = stp_reg + 2'd1;
            end
            ST_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[3'(i)] = chain_reg[3'(i)] ^ vec[{1'b0, 3'(i)}]
                                        ^ vec[{1'b1, 3'(i)}];
                end
                if (final_reg) begin
                    k_next     = 3'd0;
                    state_next = ST_OUT;
                end else begin
                    buffered_next = 7'd0;
                    state_next    = ST_WRITE;
                end
            end
            ST_WRITE: begin
                mem_wr_en     = 1'b1;
                buffered_next = buffered_reg + 7'd1;
                state_next    = eom_reg ? ST_FINCNT : ST_IDLE;
            end
            ST_FINCNT: begin
                counter_next = counter_reg + {57'd0, buffered_reg};
                final_next   = 1'b1;
                state_next   = ST_LOAD;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    if (last_k) begin
                        chain_next    = b2s_pkg::chain_init(digest_reg);
                        buffered_next = 7'd0;
                        counter_next  = 64'd0;
                        state_next    = ST_IDLE;
                    end else begin
                        k_next = k_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // length write restarts the message
        if (cfg_wr_en) begin
            digest_next   = cfg_wr_data;
            chain_next    = b2s_pkg::chain_init(cfg_wr_data);
            buffered_next = 7'd0;
            counter_next  = 64'd0;
        end
    end

    assign rd_addr = b2s_pkg::sigma_at(rnd_next, {g_next, stp_next[1]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            digest_reg   <= b2s_pkg::DIGEST_BYTES_RST;
            chain_reg    <= b2s_pkg::chain_init(b2s_pkg::DIGEST_BYTES_RST);
            buffered_reg <= 7'd0;
            counter_reg  <= 64'd0;
            final_reg    <= 1'b0;
            rnd_reg      <= 4'd0;
            g_reg        <= 3'd0;
            stp_reg      <= 2'd0;
            k_reg        <= 3'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            digest_reg   <= digest_next;
            chain_reg    <= chain_next;
            buffered_reg <= buffered_next;
            counter_reg  <= counter_next;
            final_reg    <= final_next;
            rnd_reg      <= rnd_next;
            g_reg        <= g_next;
            stp_reg      <= stp_next;
            k_reg        <= k_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            byte_reg <= s_data_byte;
            eom_reg  <= s_end_of_message;
        end
        if (out_load) begin
            word_reg  <= out_word;
            index_reg <= k_reg;
            vb_reg    <= vb;
            last_reg  <= last_k;
        end
    end

    b2s_msg_buf u_msg_buf (
        .clk     (aclk),
        .wr_en   (mem_wr_en),
        .wr_pos  (buffered_reg[5:0]),
        .wr_byte (byte_reg),
        .rd_addr (rd_addr),
        .fill    (buffered_reg),
        .rd_word (msg_word)
    );

    b2s_round_core u_round_core (
        .clk      (aclk),
        .ctrl     (ctrl),
        .chain_in (chain_reg),
        .count_in (counter_reg),
        .msg_word (msg_word),
        .vec_out  (vec)
    );

    assign m_valid       = m_valid_reg;
    assign m_digest_word = word_reg;
    assign m_word_index  = index_reg;
    assign m_valid_bytes = vb_reg;
    assign m_last_word   = last_reg;

    // byte on a full block goes through a plain compression first
    a_full_block_compress: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_take && s_has_byte && buffered_reg == BLK_BYTES)
        |=> (state_reg == ST_LOAD && !final_reg))
        else $error("full block not compressed before new byte");

    a_final_fold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD && final_reg) |=> (state_reg == ST_OUT))
        else $error("final fold did not start digest output");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> (buffered_reg < BLK_BYTES))
        else $error("byte write beyond block");

    a_more_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_word) |-> (state_reg == ST_OUT))
        else $error("digest output ended before last word");

    a_round_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |=> (state_reg == ST_ROUND || state_reg == ST_FOLD))
        else $error("round sequence left early");

endmodule

### tb/blake2s_hash_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blake2s_hash_engine_tb
// Streams byte messages into the hash engine and checks every digest word
// against an in-bench BLAKE2s model. Covers empty messages, ignored words,
// block boundaries and digest lengths from the clamped extremes up, with
// random stalls on both channels.
// ----------------------------------------------------------------------------
module blake2s_hash_engine_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 400;

    localparam logic [31:0] IV_TAB [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam int MSG_ORDER [10][16] = '{
        '{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
        '{14, 10,  4,  8,  9, 15, 13,  6,  1, 12,  0,  2, 11,  7,  5,  3},
        '{11,  8, 12,  0,  5,  2, 15, 13, 10, 14,  3,  6,  7,  1,  9,  4},
        '{ 7,  9,  3,  1, 13, 12, 11, 14,  2,  6,  5, 10,  4,  0, 15,  8},
        '{ 9,  0,  5,  7,  2,  4, 10, 15, 14,  1, 11, 12,  6,  8,  3, 13},
        '{ 2, 12,  6, 10,  0, 11,  8,  3,  4, 13,  7,  5, 15, 14,  1,  9},
        '{12,  5,  1, 15, 14, 13,  4, 10,  0,  7,  6,  3,  9,  2,  8, 11},
        '{13, 11,  7, 14, 12,  1,  3,  9,  5,  0, 15,  4,  8,  6,  2, 10},
        '{ 6, 15, 14,  9, 11,  3,  0,  8, 12,  2, 13,  7,  1,  4, 10,  5},
        '{10,  2,  8,  4,  7,  6,  1,  5, 15, 11,  9, 14,  3, 12, 13,  0}
    };

    localparam int MIX_LANES [8][4] = '{
        '{0, 4,  8, 12}, '{1, 5,  9, 13}, '{2, 6, 10, 14}, '{3, 7, 11, 15},
        '{0, 5, 10, 15}, '{1, 6, 11, 12}, '{2, 7,  8, 13}, '{3, 4,  9, 14}
    };

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eom;
    } in_word_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic [2:0]  nbytes;
        logic        last;
    } digest_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_has_byte = 1'b0;
    logic        s_end_of_message = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic [2:0]  m_valid_bytes;
    logic        m_last_word;
    logic        cfg_wr_en = 1'b0;
    logic [5:0]  cfg_wr_data = 6'd0;

    in_word_t     pending_words [$];
    digest_word_t digest_fifo [$];
    in_word_t     drv_next;
    digest_word_t mon_seen;
    digest_word_t mon_want;

    // model state
    logic [31:0] hash_chain [8];
    logic [7:0]  msg_block [64];
    int          fill_count;
    logic [63:0] total_bytes;
    logic [5:0]  digest_len;

    bit no_gaps = 1'b0;
    int cycles = 0;
    int fail_count = 0;
    int mismatch_count = 0;
    int words_accepted = 0;
    int words_checked = 0;
    int words_predicted = 0;
    int messages_done = 0;
    int length_writes = 0;
    int stim_count = 0;

    blake2s_hash_engine dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_has_byte       (s_has_byte),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_digest_word    (m_digest_word),
        .m_word_index     (m_word_index),
        .m_valid_bytes    (m_valid_bytes),
        .m_last_word      (m_last_word),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [31:0] rotr(logic [31:0] w, int n);
        return (w >> n) | (w << (32 - n));
    endfunction

    function automatic int clamp_len();
        int len;
        len = digest_len;
        if (len == 0) begin
            len = 1;
        end else if (len > 32) begin
            len = 32;
        end
        return len;
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < 8; i++) begin
            hash_chain[i] = IV_TAB[i];
        end
        hash_chain[0] = hash_chain[0] ^ (32'h0101_0000 | 32'(clamp_len()));
        for (int i = 0; i < 64; i++) begin
            msg_block[i] = 8'h00;
        end
        fill_count = 0;
        total_bytes = 64'd0;
    endfunction

    function automatic void compress_block(bit last_blk);
        logic [31:0] m [16];
        logic [31:0] v [16];
        int a, b, c, d;
        for (int i = 0; i < 16; i++) begin
            m[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
        end
        for (int i = 0; i < 8; i++) begin
            v[i] = hash_chain[i];
            v[i+8] = IV_TAB[i];
        end
        v[12] = v[12] ^ total_bytes[31:0];
        v[13] = v[13] ^ total_bytes[63:32];
        if (last_blk) begin
            v[14] = ~v[14];
        end
        for (int r = 0; r < 10; r++) begin
            for (int g = 0; g < 8; g++) begin
                a = MIX_LANES[g][0];
                b = MIX_LANES[g][1];
                c = MIX_LANES[g][2];
                d = MIX_LANES[g][3];
                v[a] = v[a] + v[b] + m[MSG_ORDER[r][2*g]];
                v[d] = rotr(v[d] ^ v[a], 16);
                v[c] = v[c] + v[d];
                v[b] = rotr(v[b] ^ v[c], 12);
                v[a] = v[a] + v[b] + m[MSG_ORDER[r][2*g+1]];
                v[d] = rotr(v[d] ^ v[a], 8);
                v[c] = v[c] + v[d];
                v[b] = rotr(v[b] ^ v[c], 7);
            end
        end
        for (int i = 0; i < 8; i++) begin
            hash_chain[i] = hash_chain[i] ^ v[i] ^ v[i+8];
        end
    endfunction

    // absorbs one accepted input word, queues the digest words on end of message
    function automatic void absorb_word(logic [7:0] data, logic has, logic eom);
        digest_word_t dw;
        int len;
        int nwords;
        int nb;
        if (has) begin
            if (fill_count == 64) begin
                total_bytes = total_bytes + 64'd64;
                compress_block(1'b0);
                fill_count = 0;
            end
            msg_block[fill_count] = data;
            fill_count++;
        end
        if (!eom) begin
            return;
        end
        total_bytes = total_bytes + 64'(fill_count);
        for (int i = fill_count; i < 64; i++) begin
            msg_block[i] = 8'h00;
        end
        compress_block(1'b1);
        len = clamp_len();
        nwords = (len + 3) / 4;
        for (int k = 0; k < nwords; k++) begin
            nb = len - 4 * k;
            if (nb > 4) begin
                nb = 4;
            end
            dw.word = hash_chain[k];
            if (nb < 4) begin
                dw.word = dw.word & ((32'd1 << (8 * nb)) - 32'd1);
            end
            dw.index = 3'(k);
            dw.nbytes = 3'(nb);
            dw.last = (k == nwords - 1);
            digest_fifo.push_back(dw);
            words_predicted++;
        end
        messages_done++;
        restart_message();
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                absorb_word(s_data_byte, s_has_byte, s_end_of_message);
                words_accepted++;
            end
            if (pending_words.size() != 0 && (no_gaps || $urandom_range(99) >= 15)) begin
                drv_next = pending_words.pop_front();
                s_valid <= 1'b1;
                s_data_byte <= drv_next.data;
                s_has_byte <= drv_next.has;
                s_end_of_message <= drv_next.eom;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                words_checked++;
                mon_seen = '{m_digest_word, m_word_index, m_valid_bytes, m_last_word};
                if (digest_fifo.size() == 0) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected digest word %h idx %0d bytes %0d last %0d",
                                 mon_seen.word, mon_seen.index, mon_seen.nbytes,
                                 mon_seen.last);
                    end
                end else begin
                    mon_want = digest_fifo.pop_front();
                    if (mon_seen.word !== mon_want.word || mon_seen.index !== mon_want.index
                        || mon_seen.nbytes !== mon_want.nbytes
                        || mon_seen.last !== mon_want.last) begin
                        fail_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("digest mismatch: exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                                     mon_want.word, mon_want.index, mon_want.nbytes,
                                     mon_want.last, mon_seen.word, mon_seen.index,
                                     mon_seen.nbytes, mon_seen.last);
                        end
                    end
                end
            end
            m_ready <= no_gaps || $urandom_range(99) >= 15;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d digest words outstanding",
                     cycles, digest_fifo.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic queue_word(logic [7:0] data, logic has, logic eom);
        pending_words.push_back('{data, has, eom});
        if (has || eom) begin
            stim_count++;
        end
    endtask

    task automatic queue_message(int len, bit sep_end);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 8) begin
                queue_word(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            queue_word(8'($urandom_range(255)), 1'b1, (i == len - 1) && !sep_end);
        end
        if (sep_end || len == 0) begin
            queue_word(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    // engine idle: everything accepted, nothing outstanding, compression drained
    task automatic settle();
        while (pending_words.size() != 0 || s_valid || digest_fifo.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_length(logic [5:0] len);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        digest_len = len;
        restart_message();
        length_writes++;
        @(negedge aclk);
    endtask

    task automatic pick_message();
        int sizes [6];
        int len;
        int r;
        sizes = '{63, 64, 65, 127, 128, 129};
        r = $urandom_range(99);
        if (r < 65) begin
            len = $urandom_range(8);
        end else if (r < 88) begin
            len = $urandom_range(40, 9);
        end else begin
            len = sizes[$urandom_range(5)];
        end
        queue_message(len, $urandom_range(99) < 30);
    endtask

    initial begin
        logic [5:0] plan [8];
        int phase;
        int target;
        int base_items;
        int base_results;
        plan = '{6'd32, 6'd16, 6'd1, 6'd29, 6'd63, 6'd8, 6'd0, 6'd32};
        digest_len = 6'd32;
        restart_message();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed
        queue_word(8'hFF, 1'b0, 1'b1);
        queue_word(8'h00, 1'b0, 1'b0);
        queue_word(8'h61, 1'b1, 1'b0);
        queue_word(8'h62, 1'b1, 1'b0);
        queue_word(8'h63, 1'b1, 1'b1);
        queue_word(8'h00, 1'b1, 1'b1);
        queue_word(8'hFF, 1'b1, 1'b1);
        queue_word(8'h5A, 1'b1, 1'b0);
        queue_word(8'hA5, 1'b1, 1'b0);
        queue_word(8'h00, 1'b0, 1'b1);
        settle();
        write_length(6'd0);
        queue_word(8'h3C, 1'b1, 1'b1);
        settle();
        write_length(6'd33);
        queue_word(8'h81, 1'b1, 1'b0);
        queue_word(8'h7E, 1'b1, 1'b1);
        settle();
        write_length(6'd63);
        queue_word(8'h00, 1'b0, 1'b1);
        settle();
        write_length(6'd4);
        for (int i = 0; i < 5; i++) begin
            queue_word(8'(8'h11 * i), 1'b1, 1'b0);
        end
        // length write drops the message in progress
        settle();
        write_length(6'd7);
        queue_word(8'h00, 1'b0, 1'b1);

        // random phases
        base_items = stim_count;
        settle();
        base_results = words_predicted;
        phase = 0;
        while (stim_count - base_items < 250 || words_predicted - base_results < 48) begin
            settle();
            no_gaps = (phase == 2);
            write_length(phase < 8 ? plan[phase] : 6'($urandom_range(63)));
            target = stim_count + 40;
            while (stim_count < target) begin
                pick_message();
            end
            phase++;
        end
        settle();
        while (digest_fifo.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        fail_count += digest_fifo.size();

        $display("ran %0d messages from %0d input words, %0d digest words checked",
                 messages_done, words_accepted, words_checked);
        $display("%0d digest length writes, clamped values 0 and 63 included", length_writes);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
